@@ rtl/pdt_pkg.sv @@
// shared constants and types of the per-source duplicate tracker
package pdt_pkg;

    // table size and derived widths
    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // field widths
    localparam int ADDR_W = 16;
    localparam int SEQ_W  = 16;
    localparam int CTR_W  = 16;
    localparam int STAT_W = 2;

    // stream widths, padded to whole bytes
    localparam int IN_BITS  = ADDR_W + SEQ_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = ADDR_W + 3 * CTR_W + STAT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // result status codes
    localparam logic [STAT_W-1:0] ST_NEW_SOURCE = 2'd0;
    localparam logic [STAT_W-1:0] ST_NEW_SEQ    = 2'd1;
    localparam logic [STAT_W-1:0] ST_DUPLICATE  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL       = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic match;
        logic resolve;
        logic update;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

@@ rtl/pdt_ctrl.sv @@
// controller state machine: sequences one request through compare, resolve and update
module pdt_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  pdt_pkg::stat_t stat,
    output pdt_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_MATCH   = 4'b0010,
        S_RESOLVE = 4'b0100,
        S_UPDATE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                state_next  = S_UPDATE;
            end
            S_UPDATE:
            begin
                // hold until the output register can take the result
                if (stat.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/pdt_datapath.sv @@
// datapath: source table, parallel address compare, counter update and result register
module pdt_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pdt_pkg::cmd_t                 cmd,
    output pdt_pkg::stat_t                stat,
    input  logic [pdt_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pdt_pkg::OUT_W-1:0]     m_tdata
);

    // table cells
    logic [pdt_pkg::ADDR_W-1:0] addr_reg [pdt_pkg::ENTRIES];
    logic [pdt_pkg::CTR_W-1:0]  recv_reg [pdt_pkg::ENTRIES];
    logic [pdt_pkg::SEQ_W-1:0]  seq_reg  [pdt_pkg::ENTRIES];
    logic [pdt_pkg::CTR_W-1:0]  dups_reg [pdt_pkg::ENTRIES];

    // cells in use, always the lowest ones
    logic [pdt_pkg::CNT_W-1:0]  fill_reg;
    logic [pdt_pkg::CTR_W-1:0]  global_reg;

    // request in flight
    logic [pdt_pkg::ADDR_W-1:0] src_reg;
    logic [pdt_pkg::SEQ_W-1:0]  req_seq_reg;
    logic [pdt_pkg::ENTRIES-1:0] match_reg;
    logic [pdt_pkg::IDX_W-1:0]  idx_reg;
    logic                       hit_reg;

    // result register
    logic                        out_valid_reg;
    logic [pdt_pkg::CTR_W-1:0]   out_recv_reg;
    logic [pdt_pkg::CTR_W-1:0]   out_dups_reg;
    logic [pdt_pkg::CTR_W-1:0]   out_global_reg;
    logic [pdt_pkg::STAT_W-1:0]  out_status_reg;
    logic [pdt_pkg::ADDR_W-1:0]  out_addr_reg;

    logic [pdt_pkg::ENTRIES-1:0] match_next;
    logic [pdt_pkg::IDX_W-1:0]   idx_next;
    logic [pdt_pkg::IDX_W-1:0]   fill_idx;
    logic                        table_full;

    assign fill_idx   = fill_reg[pdt_pkg::IDX_W-1:0];
    assign table_full = (fill_reg == pdt_pkg::CNT_W'(pdt_pkg::ENTRIES));

    // per-cell address compare, masked to cells in use
    always_comb
    begin
        for (int k = 0; k < pdt_pkg::ENTRIES; k++)
        begin
            match_next[k] = (addr_reg[k] == src_reg) &&
                            (pdt_pkg::CNT_W'(k) < fill_reg);
        end
    end

    // lowest matching cell
    always_comb
    begin
        idx_next = '0;
        for (int k = pdt_pkg::ENTRIES - 1; k >= 0; k--)
        begin
            if (match_reg[k])
            begin
                idx_next = pdt_pkg::IDX_W'(k);
            end
        end
    end

    // request capture, compare and resolve registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            src_reg     <= s_tdata[pdt_pkg::ADDR_W-1:0];
            req_seq_reg <= s_tdata[pdt_pkg::ADDR_W +: pdt_pkg::SEQ_W];
        end
        if (cmd.match)
        begin
            match_reg <= match_next;
        end
        if (cmd.resolve)
        begin
            idx_reg <= idx_next;
            hit_reg <= |match_reg;
        end
    end

    // table writes and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            out_addr_reg <= src_reg;
            if (hit_reg)
            begin
                if (seq_reg[idx_reg] != req_seq_reg)
                begin
                    recv_reg[idx_reg] <= recv_reg[idx_reg] + 1'b1;
                    seq_reg[idx_reg]  <= req_seq_reg;
                    out_recv_reg      <= recv_reg[idx_reg] + 1'b1;
                    out_dups_reg      <= dups_reg[idx_reg];
                    out_global_reg    <= global_reg;
                    out_status_reg    <= pdt_pkg::ST_NEW_SEQ;
                end
                else
                begin
                    dups_reg[idx_reg] <= dups_reg[idx_reg] + 1'b1;
                    out_recv_reg      <= recv_reg[idx_reg];
                    out_dups_reg      <= dups_reg[idx_reg] + 1'b1;
                    out_global_reg    <= global_reg + 1'b1;
                    out_status_reg    <= pdt_pkg::ST_DUPLICATE;
                end
            end
            else if (!table_full)
            begin
                addr_reg[fill_idx] <= src_reg;
                recv_reg[fill_idx] <= pdt_pkg::CTR_W'(1);
                seq_reg[fill_idx]  <= req_seq_reg;
                dups_reg[fill_idx] <= '0;
                out_recv_reg       <= pdt_pkg::CTR_W'(1);
                out_dups_reg       <= '0;
                out_global_reg     <= global_reg;
                out_status_reg     <= pdt_pkg::ST_NEW_SOURCE;
            end
            else
            begin
                out_recv_reg   <= '0;
                out_dups_reg   <= '0;
                out_global_reg <= global_reg;
                out_status_reg <= pdt_pkg::ST_FULL;
            end
        end
    end

    // fill count, global duplicate total and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            global_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                out_valid_reg <= 1'b1;
                if (hit_reg && (seq_reg[idx_reg] == req_seq_reg))
                begin
                    global_reg <= global_reg + 1'b1;
                end
                if (!hit_reg && !table_full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = pdt_pkg::OUT_W'({out_status_reg, out_global_reg, out_dups_reg,
                                            out_recv_reg, out_addr_reg});

endmodule

@@ rtl/per_source_duplicate_tracker.sv @@
// top level of the per-source duplicate tracker: controller and datapath
// a request passes the match, resolve and update states, then its result sets m_tvalid
// a new request is taken only in idle, once the previous one has left the update step
// the update step waits while the output register holds an untaken result
// reset (rst_n, asynchronous, active low) empties the table at once via the fill count
// and clears the global duplicate total and the output valid
module per_source_duplicate_tracker
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // source_addr [15:0], seq_count [31:16]
    input  logic [pdt_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // echo_addr [15:0], receive_total [31:16], dup_total_source [47:32],
    // dup_total_all [63:48], status [65:64], zero [71:66]
    output logic [pdt_pkg::OUT_W-1:0] m_tdata
);

    pdt_pkg::cmd_t  cmd;
    pdt_pkg::stat_t stat;

    // request sequencing
    pdt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table and result register
    pdt_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// testbench of the per-source duplicate tracker: stream driver, table predictor and result checker
module tb;
    import pdt_pkg::*;

    localparam int POOL_SIZE    = 44;
    localparam int RANDOM_ITEMS = 640;
    localparam int BURST_PAIRS  = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 20;

    // one expected result of the tracker
    typedef struct {
        logic [ADDR_W-1:0] echo_addr;
        logic [CTR_W-1:0]  receive_total;
        logic [CTR_W-1:0]  dup_total_source;
        logic [CTR_W-1:0]  dup_total_all;
        logic [STAT_W-1:0] status;
    } tracker_result_t;

    // source table predictor and queue of expected results
    class dup_scoreboard;
        bit                cell_used     [ENTRIES];
        logic [ADDR_W-1:0] cell_addr     [ENTRIES];
        logic [CTR_W-1:0]  cell_received [ENTRIES];
        logic [SEQ_W-1:0]  cell_last_seq [ENTRIES];
        logic [CTR_W-1:0]  cell_dups     [ENTRIES];
        logic [CTR_W-1:0]  all_dups;
        tracker_result_t   expected_q[$];
        int                errors;

        function new();
            foreach (cell_used[k])
            begin
                cell_used[k]     = 1'b0;
                cell_addr[k]     = '0;
                cell_received[k] = '0;
                cell_last_seq[k] = '0;
                cell_dups[k]     = '0;
            end
            all_dups = '0;
            errors   = 0;
        endfunction

        // work out the result of one accepted request and update the table
        function void note_request(logic [ADDR_W-1:0] src, logic [SEQ_W-1:0] seq);
            tracker_result_t res;
            int              hit;
            hit                  = -1;
            res.echo_addr        = src;
            res.receive_total    = '0;
            res.dup_total_source = '0;
            res.status           = ST_FULL;
            // lowest cell that is free or already holds this source
            for (int k = 0; k < ENTRIES && hit < 0; k++)
                if (!cell_used[k] || cell_addr[k] == src)
                    hit = k;
            if (hit >= 0)
            begin
                if (!cell_used[hit])
                begin
                    cell_used[hit]     = 1'b1;
                    cell_addr[hit]     = src;
                    cell_received[hit] = cell_received[hit] + 1'b1;
                    cell_last_seq[hit] = seq;
                    res.status         = ST_NEW_SOURCE;
                end
                else if (cell_last_seq[hit] != seq)
                begin
                    cell_received[hit] = cell_received[hit] + 1'b1;
                    cell_last_seq[hit] = seq;
                    res.status         = ST_NEW_SEQ;
                end
                else
                begin
                    all_dups       = all_dups + 1'b1;
                    cell_dups[hit] = cell_dups[hit] + 1'b1;
                    res.status     = ST_DUPLICATE;
                end
                res.receive_total    = cell_received[hit];
                res.dup_total_source = cell_dups[hit];
            end
            res.dup_total_all = all_dups;
            expected_q.push_back(res);
        endfunction

        function void check_field(string name, logic [CTR_W-1:0] want, logic [CTR_W-1:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // compare one result with the oldest expectation
        function void check_result(logic [OUT_W-1:0] data);
            tracker_result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with no request outstanding, expected none, actual %h",
                         $time, data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            check_field("echo_addr", want.echo_addr, data[0 +: ADDR_W]);
            check_field("receive_total", want.receive_total, data[ADDR_W +: CTR_W]);
            check_field("dup_total_source", want.dup_total_source,
                        data[ADDR_W + CTR_W +: CTR_W]);
            check_field("dup_total_all", want.dup_total_all, data[ADDR_W + 2 * CTR_W +: CTR_W]);
            check_field("status", CTR_W'(want.status), CTR_W'(data[ADDR_W + 3 * CTR_W +: STAT_W]));
            check_field("padding", '0, CTR_W'(data[OUT_W-1:OUT_BITS]));
        endfunction
    endclass

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    dup_scoreboard     sb;
    int                tx_idle_pct  = 8;
    int                rx_idle_pct  = 68;
    int                results_seen = 0;
    int                hold_left    = 0;
    bit                hold_done    = 1'b0;
    int                stall_cycles = 0;
    logic [ADDR_W-1:0] pool_addr [POOL_SIZE];
    logic [SEQ_W-1:0]  pool_seq  [POOL_SIZE];

    per_source_duplicate_tracker dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off so the block backs up
    always @(posedge clk)
    begin
        if (rst_n && !hold_done && results_seen == 40)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata);
            results_seen <= results_seen + 1;
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // offer one request, with random gaps before it, and note it once taken
    task automatic send_request(input logic [ADDR_W-1:0] addr, input logic [SEQ_W-1:0] seq);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {seq, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(addr, seq);
    endtask

    // mostly known sources with repeated or fresh counts, some stray addresses
    task automatic run_random(input int count);
        int                slot;
        int                pick;
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        repeat (count)
        begin
            pick = $urandom_range(99);
            slot = $urandom_range(POOL_SIZE - 1);
            if (pick < 10)
            begin
                addr = ADDR_W'($urandom);
                seq  = SEQ_W'($urandom);
            end
            else
            begin
                addr = pool_addr[slot];
                if (pick < 50)
                    seq = pool_seq[slot];
                else if (pick < 80)
                    seq = pool_seq[slot] + 1'b1;
                else
                    seq = SEQ_W'($urandom);
                pool_seq[slot] = seq;
            end
            send_request(addr, seq);
        end
    endtask

    initial
    begin
        logic [SEQ_W-1:0] burst_seq;
        sb = new();
        foreach (pool_addr[k])
        begin
            pool_addr[k] = ADDR_W'($urandom);
            pool_seq[k]  = SEQ_W'($urandom);
        end

        // reset
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: address zero against empty cells, all-ones address, extreme counts
        send_request(16'h0000, 16'h0000);
        send_request(16'h0000, 16'h0000);
        send_request(16'h0000, 16'hffff);
        send_request(16'h0000, 16'hffff);
        send_request(16'hffff, 16'hffff);
        send_request(16'hffff, 16'hffff);
        send_request(16'hffff, 16'h0000);
        send_request(16'haaaa, 16'h5555);
        send_request(16'h5555, 16'haaaa);
        send_request(16'haaaa, 16'h5555);
        send_request(16'h5555, 16'h5555);
        send_request(16'h0001, 16'h8000);
        send_request(16'h8000, 16'h0001);
        send_request(16'h0000, 16'h0000);
        send_request(16'h0000, 16'h0000);

        // random traffic, table fills and then reports full
        run_random(RANDOM_ITEMS);
        tx_idle_pct = 68;
        rx_idle_pct = 8;
        run_random(RANDOM_ITEMS);

        // fresh count then duplicate on one source, back to back with no idling
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < BURST_PAIRS; i++)
        begin
            burst_seq = i[0] ? 16'h00ff : 16'hff00;
            send_request(16'h0000, burst_seq);
            send_request(16'h0000, burst_seq);
        end
        s_tvalid <= 1'b0;

        // drain
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
